// ----- hw/rtl/ultrasonic_echo_timer_macros.svh -----
// ---------------------------------------------------------------------------
// ultrasonic echo timer assertion macros
// shared concurrent assertion wrappers, clocked on clk, gated by rst_n
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_TIMER_MACROS_SVH
`define ULTRASONIC_ECHO_TIMER_MACROS_SVH

// same-cycle implication
`define UET_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uet assertion failed");

// next-cycle implication
`define UET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uet assertion failed");

`endif

// ----- hw/rtl/uet_pkg.sv -----
// ---------------------------------------------------------------------------
// uet_pkg
// types and constants shared by the ultrasonic echo timer modules
// ---------------------------------------------------------------------------
package uet_pkg;

  localparam int unsigned TICK_W    = 17;
  localparam int unsigned ECHO_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [ECHO_W-1:0] MAX_ECHO_RST = 16'd18000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLE = 8'd1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_PULSE = 3'd2,
    PH_CLEAR = 3'd3,
    PH_RISE  = 3'd4,
    PH_HIGH  = 3'd5
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } uet_in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [ECHO_W-1:0] echo_time;
    logic              no_echo;
  } uet_out_t;

  typedef struct packed {
    logic [ECHO_W-1:0] max_echo_time;
    logic              sensor_enable;
  } uet_cfg_t;

endpackage

// ----- hw/rtl/uet_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// uet_cfg_regs
// configuration register file: echo length limit and sensor enable
// ---------------------------------------------------------------------------
module uet_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [uet_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [uet_pkg::CFG_DAT_W-1:0]  wr_data,
  output uet_pkg::uet_cfg_t              cfg
);

  logic [uet_pkg::ECHO_W-1:0] max_echo_r;
  logic [uet_pkg::ECHO_W-1:0] max_echo_nxt;
  logic                       enable_r;
  logic                       enable_nxt;

  always_comb begin
    max_echo_nxt = max_echo_r;
    enable_nxt   = enable_r;
    if (wr_en) begin
      unique case (wr_index)
        uet_pkg::REG_MAX_ECHO_TIME: max_echo_nxt = wr_data[uet_pkg::ECHO_W-1:0];
        uet_pkg::REG_SENSOR_ENABLE: enable_nxt   = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_echo_r <= uet_pkg::MAX_ECHO_RST;
      enable_r   <= 1'b1;
    end else begin
      max_echo_r <= max_echo_nxt;
      enable_r   <= enable_nxt;
    end
  end

  assign cfg.max_echo_time = max_echo_r;
  assign cfg.sensor_enable = enable_r;

endmodule

// ----- hw/rtl/uet_ping_fsm.sv -----
// ---------------------------------------------------------------------------
// uet_ping_fsm
// ping sequencer: pre-delay, trigger pulse, echo wait and echo timing
// ---------------------------------------------------------------------------
module uet_ping_fsm #(
  parameter int unsigned START_TIMEOUT  = 18000,
  parameter int unsigned PRE_DELAY      = 4,
  parameter int unsigned PULSE_TICKS    = 10,
  parameter int unsigned OVERHEAD_TICKS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  uet_pkg::uet_in_t   item,
  input  uet_pkg::uet_cfg_t  cfg,
  output uet_pkg::uet_out_t  result
);

  localparam int unsigned TW = uet_pkg::TICK_W;
  localparam int unsigned EW = uet_pkg::ECHO_W;

  uet_pkg::phase_t phase_r;
  uet_pkg::phase_t phase_nxt;
  uet_pkg::phase_t start_phase;
  logic [TW-1:0]   cnt_r;
  logic [TW-1:0]   cnt_nxt;
  logic [TW-1:0]   start_cnt;
  logic [TW-1:0]   cnt_inc;
  logic [TW-1:0]   cnt_diff;
  logic [EW-1:0]   last_time_r;
  logic [EW-1:0]   last_time_nxt;
  logic            last_to_r;
  logic            last_to_nxt;
  logic            go;
  logic            late;
  logic            overrun;
  logic            trig;
  logic            done;

  assign go       = item.start_req && cfg.sensor_enable;
  assign cnt_inc  = cnt_r + TW'(1);
  assign cnt_diff = cnt_r - TW'(OVERHEAD_TICKS);
  assign late     = cnt_r > TW'(START_TIMEOUT);
  assign overrun  = cnt_r > {1'b0, cfg.max_echo_time};

  // phase and count entered on an accepted start
  always_comb begin
    if (PRE_DELAY > 0) begin
      if (PRE_DELAY <= 1) begin
        start_phase = uet_pkg::PH_PULSE;
        start_cnt   = '0;
      end else begin
        start_phase = uet_pkg::PH_PRE;
        start_cnt   = TW'(1);
      end
    end else begin
      if (PULSE_TICKS <= 1) begin
        start_phase = uet_pkg::PH_CLEAR;
        start_cnt   = '0;
      end else begin
        start_phase = uet_pkg::PH_PULSE;
        start_cnt   = TW'(1);
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    last_time_nxt = last_time_r;
    last_to_nxt   = last_to_r;
    unique case (phase_r) inside
      uet_pkg::PH_IDLE: begin
        if (go) begin
          phase_nxt = start_phase;
          cnt_nxt   = start_cnt;
        end
      end
      uet_pkg::PH_PRE: begin
        if (cnt_inc >= TW'(PRE_DELAY)) begin
          phase_nxt = uet_pkg::PH_PULSE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      uet_pkg::PH_PULSE: begin
        if (cnt_inc >= TW'(PULSE_TICKS)) begin
          phase_nxt = uet_pkg::PH_CLEAR;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      uet_pkg::PH_CLEAR, uet_pkg::PH_RISE: begin
        if (item.echo_level) begin
          if (phase_r == uet_pkg::PH_CLEAR && !late) begin
            cnt_nxt = cnt_inc;
          end else begin
            phase_nxt = uet_pkg::PH_HIGH;
            cnt_nxt   = TW'(1);
          end
        end else if (late) begin
          phase_nxt     = uet_pkg::PH_IDLE;
          cnt_nxt       = '0;
          last_time_nxt = '0;
          last_to_nxt   = 1'b1;
        end else begin
          phase_nxt = uet_pkg::PH_RISE;
          cnt_nxt   = cnt_inc;
        end
      end
      uet_pkg::PH_HIGH: begin
        if (item.echo_level) begin
          if (overrun) begin
            phase_nxt     = uet_pkg::PH_IDLE;
            cnt_nxt       = '0;
            last_time_nxt = '0;
            last_to_nxt   = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          phase_nxt     = uet_pkg::PH_IDLE;
          cnt_nxt       = '0;
          last_time_nxt = cnt_diff[EW-1:0];
          last_to_nxt   = 1'b0;
        end
      end
      default: begin
        phase_nxt = uet_pkg::PH_IDLE;
        if (go) begin
          phase_nxt = start_phase;
          cnt_nxt   = start_cnt;
        end
      end
    endcase
  end

  // per-tick outputs
  always_comb begin
    trig = 1'b0;
    done = 1'b0;
    unique case (phase_r) inside
      uet_pkg::PH_PULSE:                   trig = 1'b1;
      uet_pkg::PH_CLEAR, uet_pkg::PH_RISE: done = !item.echo_level && late;
      uet_pkg::PH_HIGH:                    done = item.echo_level ? overrun : 1'b1;
      uet_pkg::PH_PRE:                     ;
      default:                             trig = go && (PRE_DELAY == 0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= uet_pkg::PH_IDLE;
      cnt_r       <= '0;
      last_time_r <= '0;
      last_to_r   <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      last_time_r <= last_time_nxt;
      last_to_r   <= last_to_nxt;
    end
  end

  assign result.trigger_level = trig;
  assign result.busy_res      = phase_nxt != uet_pkg::PH_IDLE;
  assign result.done_res      = done;
  assign result.echo_time     = last_time_nxt;
  assign result.no_echo       = last_to_nxt;

endmodule

// ----- hw/rtl/ultrasonic_echo_timer.sv -----
// ---------------------------------------------------------------------------
// ultrasonic_echo_timer
// ultrasonic rangefinder ping sequencer and echo timer, one tick per item
// ---------------------------------------------------------------------------
// usage:
//   each input transaction on in_* is one microsecond tick carrying the
//   start request and the sampled echo level. every input transaction gives
//   exactly one result transaction on out_*: trigger pin level, busy, done,
//   last echo time and the no-echo flag.
//   cfg_* writes the echo length limit (index 0) and sensor enable (index 1);
//   cfg_ready stays high: the user must hold writes until the block is idle.
// pipeline and throughput:
//   a taken tick passes the input register, then the result register;
//   one tick per cycle sustained while out_stall is low, set by the per-tick
//   phase and counter update in the sequencer.
// reset:
//   rst_n low returns the sequencer to idle, clears the last result and
//   reloads the registers (limit 18000, sensor enabled); both channels empty.
// stall:
//   out_stall holds the result register; one more tick is taken into the
//   input register, after which in_stall rises until the result drains.
// ---------------------------------------------------------------------------
module ultrasonic_echo_timer #(
  parameter int unsigned START_TIMEOUT  = 18000,
  parameter int unsigned PRE_DELAY      = 4,
  parameter int unsigned PULSE_TICKS    = 10,
  parameter int unsigned OVERHEAD_TICKS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  uet_pkg::uet_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output uet_pkg::uet_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uet_pkg::CFG_DAT_W-1:0] cfg_data
);

`include "ultrasonic_echo_timer_macros.svh"

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  uet_pkg::uet_in_t  s1_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  uet_pkg::uet_out_t out_data_r;
  uet_pkg::uet_out_t fsm_result;
  uet_pkg::uet_cfg_t cfg;
  logic              out_adv;
  logic              fire;
  logic              in_acc;

  assign cfg_ready = 1'b1;

  uet_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  uet_ping_fsm #(
    .START_TIMEOUT  (START_TIMEOUT),
    .PRE_DELAY      (PRE_DELAY),
    .PULSE_TICKS    (PULSE_TICKS),
    .OVERHEAD_TICKS (OVERHEAD_TICKS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (fsm_result)
  );

  assign out_adv  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_adv ? fire : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= fsm_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `UET_ASSERT_NEXT(a_fire_gives_result, fire, out_valid)
  `UET_ASSERT_SAME(a_done_not_busy, out_valid && out_data.done_res, !out_data.busy_res)
  `UET_ASSERT_SAME(a_trig_busy, out_valid && out_data.trigger_level, out_data.busy_res)
  `UET_ASSERT_SAME(a_no_echo_zero, out_valid && out_data.no_echo, out_data.echo_time == '0)

endmodule

// ----- tb/sv/tb_ultrasonic_echo_timer.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ultrasonic_echo_timer
// self-checking bench for the ultrasonic echo timer: every tick transaction
// is run through a local model of the ping sequencer and the result stream
// is compared field by field, under random idling, a long output stall
// and register changes between phases
// ---------------------------------------------------------------------------
module tb_ultrasonic_echo_timer;

  localparam int unsigned WAIT_LIMIT   = 18000;
  localparam int unsigned PRE_TICKS    = 4;
  localparam int unsigned TRIG_TICKS   = 10;
  localparam int unsigned LAG_TICKS    = 5;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned EW           = uet_pkg::ECHO_W;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  uet_pkg::uet_in_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  uet_pkg::uet_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [uet_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [uet_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

  // model of the sequencer and its registers
  uet_pkg::phase_t            ph        = uet_pkg::PH_IDLE;
  logic [uet_pkg::TICK_W-1:0] tc        = '0;
  logic [EW-1:0]              last_time = '0;
  logic                       last_to   = 1'b0;
  logic [EW-1:0]              max_echo  = uet_pkg::MAX_ECHO_RST;
  logic                       enable    = 1'b1;

  uet_pkg::uet_out_t pending_readings[$];
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned ticks_sent    = 0;
  int unsigned pings_run     = 0;
  int unsigned echoes_timed  = 0;
  int unsigned no_echo_ends  = 0;
  int unsigned reg_writes    = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  ultrasonic_echo_timer #(
    .START_TIMEOUT  (WAIT_LIMIT),
    .PRE_DELAY      (PRE_TICKS),
    .PULSE_TICKS    (TRIG_TICKS),
    .OVERHEAD_TICKS (LAG_TICKS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void end_ping(input logic [EW-1:0] value, input logic timed_out);
    last_time = value;
    last_to   = timed_out;
    ph        = uet_pkg::PH_IDLE;
    tc        = '0;
    if (timed_out) no_echo_ends++;
    else echoes_timed++;
  endfunction

  function automatic uet_pkg::uet_out_t next_reading(input uet_pkg::uet_in_t t);
    uet_pkg::uet_out_t r;
    logic              late;
    r = '0;
    case (ph)
      uet_pkg::PH_IDLE: begin
        if (t.start_req && enable) begin
          pings_run++;
          if (PRE_TICKS > 0) begin
            ph = uet_pkg::PH_PRE;
            tc = 1;
            if (tc >= PRE_TICKS) begin
              ph = uet_pkg::PH_PULSE;
              tc = '0;
            end
          end else begin
            r.trigger_level = 1'b1;
            ph = uet_pkg::PH_PULSE;
            tc = 1;
            if (tc >= TRIG_TICKS) begin
              ph = uet_pkg::PH_CLEAR;
              tc = '0;
            end
          end
        end
      end
      uet_pkg::PH_PRE: begin
        tc = tc + 1'b1;
        if (tc >= PRE_TICKS) begin
          ph = uet_pkg::PH_PULSE;
          tc = '0;
        end
      end
      uet_pkg::PH_PULSE: begin
        r.trigger_level = 1'b1;
        tc = tc + 1'b1;
        if (tc >= TRIG_TICKS) begin
          ph = uet_pkg::PH_CLEAR;
          tc = '0;
        end
      end
      uet_pkg::PH_CLEAR, uet_pkg::PH_RISE: begin
        late = (tc > WAIT_LIMIT);
        if (t.echo_level) begin
          if (ph == uet_pkg::PH_CLEAR && !late) begin
            tc = tc + 1'b1;
          end else begin
            ph = uet_pkg::PH_HIGH;
            tc = 1;
          end
        end else if (late) begin
          end_ping('0, 1'b1);
          r.done_res = 1'b1;
        end else begin
          ph = uet_pkg::PH_RISE;
          tc = tc + 1'b1;
        end
      end
      uet_pkg::PH_HIGH: begin
        if (t.echo_level) begin
          if (tc > max_echo) begin
            end_ping('0, 1'b1);
            r.done_res = 1'b1;
          end else begin
            tc = tc + 1'b1;
          end
        end else begin
          end_ping(EW'(tc - LAG_TICKS), 1'b0);
          r.done_res = 1'b1;
        end
      end
      default: ph = uet_pkg::PH_IDLE;
    endcase
    r.busy_res  = (ph != uet_pkg::PH_IDLE);
    r.echo_time = last_time;
    r.no_echo   = last_to;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // result side: random stalls plus an optional long hold
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_left   = LONG_HOLD;
      hold_served = hold_requests;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < rx_idle_pct);
    if (hold_left > 0) hold_left--;
  end

  // transaction monitor, model update, result check and watchdog
  always @(posedge clk) begin
    uet_pkg::uet_out_t want;
    logic              moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        reg_writes++;
        case (cfg_index)
          uet_pkg::REG_MAX_ECHO_TIME: max_echo = cfg_data;
          uet_pkg::REG_SENSOR_ENABLE: enable   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        ticks_sent++;
        pending_readings.push_back(next_reading(in_data));
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transaction: %p", out_data);
        end else begin
          want = pending_readings.pop_front();
          check_field("trigger_level", want.trigger_level, out_data.trigger_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("echo_time", want.echo_time, out_data.echo_time);
          check_field("no_echo", want.no_echo, out_data.no_echo);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[ultrasonic_echo_timer] ERROR");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{start_req: start, echo_level: echo};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [uet_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uet_pkg::CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // start tick, rest of pre-delay and pulse, stale echo, gap, echo pulse, end, tail
  task automatic run_ping(input int unsigned stale, input int unsigned gap,
                          input int unsigned width, input int unsigned tail);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (PRE_TICKS + TRIG_TICKS - 1)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (stale) send_tick(1'($urandom_range(0, 1)), 1'b1);
    repeat (gap) send_tick(1'($urandom_range(0, 1)), 1'b0);
    repeat (width) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (tail) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_clean_echo();
    run_ping(0, 3, 12, 2);
    run_ping(2, 3, 12, 2);
  endtask

  task automatic test_short_echo_wraps();
    run_ping(0, 2, 1, 1);
    run_ping(0, 2, 5, 1);
  endtask

  task automatic test_echo_limit();
    write_reg(uet_pkg::REG_MAX_ECHO_TIME, 16'd0);
    run_ping(0, 2, 3, 1);
    write_reg(uet_pkg::REG_MAX_ECHO_TIME, 16'd7);
    run_ping(0, 1, 8, 1);
    run_ping(0, 1, 9, 1);
    write_reg(uet_pkg::REG_MAX_ECHO_TIME, 16'hFFFF);
    run_ping(0, 1, 40, 1);
  endtask

  task automatic test_disabled();
    write_reg(uet_pkg::REG_SENSOR_ENABLE, 16'hFFFE);
    run_ping(0, 2, 5, 1);
    write_reg(uet_pkg::REG_SENSOR_ENABLE, 16'h0001);
    run_ping(0, 2, 6, 1);
  endtask

  task automatic test_unknown_register();
    write_reg(8'hFF, 16'h0000);
    write_reg(8'h02, 16'h0000);
    run_ping(1, 2, 10, 1);
  endtask

  task automatic test_backpressure();
    hold_requests++;
    run_ping(1, 5, 20, 3);
    run_ping(0, 4, 15, 2);
  endtask

  task automatic random_pings(input int unsigned n_ticks);
    int unsigned goal;
    int unsigned width;
    goal = ticks_sent + n_ticks;
    while (ticks_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        width = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
        run_ping($urandom_range(0, 4), $urandom_range(0, 10), width, $urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 21;
    rx_idle_pct = 67;
    test_idle_ticks();
    test_clean_echo();
    test_short_echo_wraps();
    test_echo_limit();
    test_disabled();
    test_unknown_register();
    write_reg(uet_pkg::REG_MAX_ECHO_TIME, 16'($urandom_range(4, 40)));
    random_pings(300);

    tx_idle_pct = 67;
    rx_idle_pct = 21;
    test_backpressure();
    write_reg(uet_pkg::REG_MAX_ECHO_TIME, 16'($urandom_range(60, 200)));
    random_pings(150);
    write_reg(uet_pkg::REG_SENSOR_ENABLE, 16'h0000);
    random_pings(50);
    write_reg(uet_pkg::REG_SENSOR_ENABLE, 16'h0001);
    random_pings(100);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(uet_pkg::REG_MAX_ECHO_TIME, 16'($urandom_range(10, 30)));
    random_pings(320);

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ticks, %0d pings, %0d timed echoes, %0d no-echo endings",
             ticks_sent, pings_run, echoes_timed, no_echo_ends);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("[ultrasonic_echo_timer] OK");
    end else begin
      $display("[ultrasonic_echo_timer] ERROR");
    end
    $finish;
  end

endmodule
